FILE: design/dqsr_pkg.sv
// ============================================================================
// dqsr_pkg
// Shared types and constants for the deque with search and remove.
// ============================================================================
package dqsr_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam int FUNC_W   = 3;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;

    localparam int S_TDATA_W = ((FUNC_W + VAL_W + 7) / 8) * 8;
    localparam int M_BITS    = STATUS_W + 1 + VAL_W + VAL_W + CNT_W + 1;
    localparam int M_TDATA_W = ((M_BITS + 7) / 8) * 8;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_FRONT = 3'd0,
        FN_PUSH_BACK  = 3'd1,
        FN_POP_FRONT  = 3'd2,
        FN_POP_BACK   = 3'd3,
        FN_CONTAINS   = 3'd4,
        FN_REMOVE     = 3'd5,
        FN_NOP6       = 3'd6,
        FN_NOP7       = 3'd7
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_MISS  = 2'd3
    } status_t;

    typedef struct packed {
        logic load;
        logic exec;
    } dqsr_cmd_t;

endpackage

FILE: design/dqsr_datapath.sv
// ============================================================================
// dqsr_datapath
// Row of storage cells with per-cell compare, shift logic and result regs.
// ============================================================================
module dqsr_datapath (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  dqsr_pkg::dqsr_cmd_t        cmd,
    input  logic [dqsr_pkg::FUNC_W-1:0] in_func,
    input  logic signed [dqsr_pkg::VAL_W-1:0] in_value,
    output logic [dqsr_pkg::STATUS_W-1:0] status,
    output logic                       found,
    output logic signed [dqsr_pkg::VAL_W-1:0] front_value,
    output logic signed [dqsr_pkg::VAL_W-1:0] back_value,
    output logic [dqsr_pkg::CNT_W-1:0] occupancy,
    output logic                       is_empty
);
    import dqsr_pkg::*;

    logic [VAL_W-1:0]    entries_reg [DEPTH];
    logic [VAL_W-1:0]    entries_next [DEPTH];
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    func_t               func_reg;
    logic [VAL_W-1:0]    opv_reg;
    status_t             status_reg, status_next;
    logic                found_reg, found_next;

    logic [DEPTH-1:0]    match;
    logic [DEPTH-1:0]    hit_upto;
    logic                any_hit;
    logic                full;
    logic                empty;
    logic [IDX_W-1:0]    back_idx;

    always_comb begin
        full  = (cnt_reg == CNT_W'(DEPTH));
        empty = (cnt_reg == '0);
        for (int i = 0; i < DEPTH; i++) begin
            match[i] = (CNT_W'(i) < cnt_reg) && (entries_reg[i] == opv_reg);
        end
        for (int i = 0; i < DEPTH; i++) begin
            hit_upto[i] = |(match & ({DEPTH{1'b1}} >> (DEPTH - 1 - i)));
        end
        any_hit = hit_upto[DEPTH-1];
    end

    always_comb begin
        entries_next = entries_reg;
        cnt_next     = cnt_reg;
        status_next  = ST_OK;
        found_next   = 1'b0;
        unique case (func_reg)
            FN_PUSH_FRONT: begin
                if (full) begin
                    status_next = ST_FULL;
                end else begin
                    entries_next[0] = opv_reg;
                    for (int i = 1; i < DEPTH; i++) begin
                        entries_next[i] = entries_reg[i-1];
                    end
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            FN_PUSH_BACK: begin
                if (full) begin
                    status_next = ST_FULL;
                end else begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (CNT_W'(i) == cnt_reg) begin
                            entries_next[i] = opv_reg;
                        end
                    end
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            FN_POP_FRONT: begin
                if (empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    for (int i = 0; i < DEPTH - 1; i++) begin
                        entries_next[i] = entries_reg[i+1];
                    end
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            FN_POP_BACK: begin
                if (empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            FN_CONTAINS: begin
                if (any_hit) begin
                    found_next = 1'b1;
                end else begin
                    status_next = ST_MISS;
                end
            end
            FN_REMOVE: begin
                if (any_hit) begin
                    found_next = 1'b1;
                    for (int i = 0; i < DEPTH - 1; i++) begin
                        if (hit_upto[i]) begin
                            entries_next[i] = entries_reg[i+1];
                        end
                    end
                    cnt_next = cnt_reg - 1'b1;
                end else begin
                    status_next = ST_MISS;
                end
            end
            FN_NOP6, FN_NOP7: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg <= func_t'(in_func);
            opv_reg  <= in_value;
        end
        if (cmd.exec) begin
            entries_reg <= entries_next;
            status_reg  <= status_next;
            found_reg   <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.exec) begin
            cnt_reg <= cnt_next;
        end
    end

    assign back_idx    = IDX_W'(cnt_reg - 1'b1);
    assign status      = status_reg;
    assign found       = found_reg;
    assign front_value = empty ? '0 : entries_reg[0];
    assign back_value  = empty ? '0 : entries_reg[back_idx];
    assign occupancy   = cnt_reg;
    assign is_empty    = empty;

endmodule

FILE: design/dqsr_ctrl.sv
// ============================================================================
// dqsr_ctrl
// Sequencer: takes a beat, runs one update, holds the result until taken.
// ============================================================================
module dqsr_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output dqsr_pkg::dqsr_cmd_t cmd
);
    import dqsr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SEND
    } state_t;

    state_t state_reg;
    logic   s_tready_reg;
    logic   m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            s_tready_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid && s_tready_reg) begin
                        state_reg    <= S_EXEC;
                        s_tready_reg <= 1'b0;
                    end else begin
                        s_tready_reg <= 1'b1;
                    end
                end
                S_EXEC: begin
                    state_reg    <= S_SEND;
                    m_tvalid_reg <= 1'b1;
                end
                S_SEND: begin
                    if (m_tready) begin
                        state_reg    <= S_IDLE;
                        m_tvalid_reg <= 1'b0;
                        s_tready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = s_tready_reg;
    assign m_tvalid = m_tvalid_reg;
    assign cmd.load = s_tvalid && s_tready_reg;
    assign cmd.exec = (state_reg == S_EXEC);

endmodule

FILE: design/deque_with_search_remove_core.sv
// ============================================================================
// deque_with_search_remove_core
// Bounded deque and bag of signed 32-bit values with search and remove.
// ============================================================================
// Input beat (s_): one operation: push front/back, pop front/back, contains,
// or remove the first match from the front. Output beat (m_): one result per
// input beat with status, found flag, front and back values, occupancy and
// empty flag, all as they stand after the operation.
// Storage is a row of 16 cells; every cell compares against the operand in
// parallel and shifts in place, so each operation is a single row update.
// Timing: a beat accepted at one edge is executed at the next, where m_tvalid
// also rises; the result then holds until taken. One item at a time: no new
// beat is taken until the result has been taken, set by the accept/execute/send
// sequence of the controller.
// While m_tvalid is high and m_tready low the result holds steady and no new
// input beat is taken (s_tready stays low).
// Reset (aresetn low, synchronous): the store is emptied and no result is
// pending; s_tready is low in reset and rises once reset is released.
// ============================================================================
module deque_with_search_remove_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [2:0] func, [34:3] operand_value
    input  logic [dqsr_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [1:0] status, [2] found, [34:3] front_value, [66:35] back_value,
    // [71:67] occupancy, [72] is_empty
    output logic [dqsr_pkg::M_TDATA_W-1:0]  m_tdata
);
    import dqsr_pkg::*;

    dqsr_cmd_t             cmd;
    logic [STATUS_W-1:0]   status;
    logic                  found;
    logic signed [VAL_W-1:0] front_value;
    logic signed [VAL_W-1:0] back_value;
    logic [CNT_W-1:0]      occupancy;
    logic                  is_empty;

    dqsr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    dqsr_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .in_func     (s_tdata[FUNC_W-1:0]),
        .in_value    (s_tdata[FUNC_W +: VAL_W]),
        .status      (status),
        .found       (found),
        .front_value (front_value),
        .back_value  (back_value),
        .occupancy   (occupancy),
        .is_empty    (is_empty)
    );

    assign m_tdata = M_TDATA_W'({is_empty, occupancy, back_value, front_value, found, status});

endmodule

FILE: sim/deque_with_search_remove_core_test.sv
// ----------------------------------------------------------------------------
// deque_with_search_remove_core_test
// Self-checking bench for the deque with search and remove.
// Operations go in on the s_ stream in bursts with random gaps. Results come
// back on the m_ stream against a stalling receiver that also holds off once
// for a long stretch. An in-bench model of the 16-entry store predicts every
// result, and each returned beat is compared field by field, in order.
// ----------------------------------------------------------------------------
module deque_with_search_remove_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dqsr_pkg::*;

    localparam int N_RANDOM = 1300;

    typedef struct packed {
        status_t           status;
        logic              found;
        logic [VAL_W-1:0]  front;
        logic [VAL_W-1:0]  back;
        logic [CNT_W-1:0]  occ;
        logic              empty;
    } dq_result_t;

    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} traffic_t;

    class deque_scoreboard;
        logic [VAL_W-1:0] cells[DEPTH];
        int               fill;
        dq_result_t       outcomes_due[$];
        int errors, n_checked, n_full, n_empty, n_miss, n_hit, peak;

        function new();
            fill = 0;
            errors = 0;
            n_checked = 0;
            n_full = 0;
            n_empty = 0;
            n_miss = 0;
            n_hit = 0;
            peak = 0;
        endfunction

        function void note_op(func_t f, logic [VAL_W-1:0] v);
            dq_result_t r;
            int pos;
            r.status = ST_OK;
            r.found = 1'b0;
            pos = -1;
            for (int i = fill - 1; i >= 0; i--)
                if (cells[i] == v) pos = i;
            case (f)
                FN_PUSH_FRONT: begin
                    if (fill >= DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        for (int i = fill; i > 0; i--) cells[i] = cells[i-1];
                        cells[0] = v;
                        fill++;
                    end
                end
                FN_PUSH_BACK: begin
                    if (fill >= DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        cells[fill] = v;
                        fill++;
                    end
                end
                FN_POP_FRONT: begin
                    if (fill == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        for (int i = 0; i < fill - 1; i++) cells[i] = cells[i+1];
                        fill--;
                    end
                end
                FN_POP_BACK: begin
                    if (fill == 0) r.status = ST_EMPTY;
                    else fill--;
                end
                FN_CONTAINS: begin
                    if (pos >= 0) r.found = 1'b1;
                    else r.status = ST_MISS;
                end
                FN_REMOVE: begin
                    if (pos >= 0) begin
                        r.found = 1'b1;
                        for (int i = pos; i < fill - 1; i++) cells[i] = cells[i+1];
                        fill--;
                    end else begin
                        r.status = ST_MISS;
                    end
                end
                default: ;
            endcase
            r.front = (fill > 0) ? cells[0] : '0;
            r.back  = (fill > 0) ? cells[fill-1] : '0;
            r.occ   = CNT_W'(fill);
            r.empty = (fill == 0);
            case (r.status)
                ST_FULL:  n_full++;
                ST_EMPTY: n_empty++;
                ST_MISS:  n_miss++;
                default:  ;
            endcase
            if (r.found) n_hit++;
            if (fill > peak) peak = fill;
            outcomes_due.push_back(r);
        endfunction

        task report_mismatch(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
            errors++;
            if (errors <= 40)
                $display("MISMATCH result %0d: %s got %h expected %h",
                         n_checked, what, got, want);
        endtask

        task check_result(logic [M_TDATA_W-1:0] d);
            dq_result_t e;
            if (outcomes_due.size() == 0) begin
                report_mismatch("unexpected beat, low word", d[VAL_W-1:0], '0);
            end else begin
                e = outcomes_due.pop_front();
                if (d[1:0] != e.status)     report_mismatch("status", d[1:0], e.status);
                if (d[2] != e.found)        report_mismatch("found", d[2], e.found);
                if (d[34:3] != e.front)     report_mismatch("front_value", d[34:3], e.front);
                if (d[66:35] != e.back)     report_mismatch("back_value", d[66:35], e.back);
                if (d[71:67] != e.occ)      report_mismatch("occupancy", d[71:67], e.occ);
                if (d[72] != e.empty)       report_mismatch("is_empty", d[72], e.empty);
            end
            n_checked++;
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    deque_scoreboard sb = new();
    logic [VAL_W-1:0] val_pool[8];
    int n_sent     = 0;
    int n_directed = 0;
    int burst_left = 0;

    deque_with_search_remove_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    task automatic drive_op(func_t f, logic [VAL_W-1:0] v);
        int gap;
        s_tdata  <= {{(S_TDATA_W-FUNC_W-VAL_W){1'b0}}, v, f};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_op(f, v);
        n_sent++;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end else begin
            burst_left--;
        end
    endtask

    function automatic func_t pick_func(traffic_t mode);
        int r;
        r = $urandom_range(0, 99);
        if (r < 2) return ($urandom_range(0, 1) != 0) ? FN_NOP6 : FN_NOP7;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_FILL: begin
                if (r < 40) return FN_PUSH_FRONT;
                if (r < 75) return FN_PUSH_BACK;
                if (r < 84) return FN_CONTAINS;
                if (r < 92) return FN_REMOVE;
                if (r < 96) return FN_POP_FRONT;
                return FN_POP_BACK;
            end
            MODE_DRAIN: begin
                if (r < 30) return FN_POP_FRONT;
                if (r < 58) return FN_POP_BACK;
                if (r < 78) return FN_REMOVE;
                if (r < 88) return FN_CONTAINS;
                if (r < 94) return FN_PUSH_FRONT;
                return FN_PUSH_BACK;
            end
            default: begin
                if (r < 18) return FN_PUSH_FRONT;
                if (r < 36) return FN_PUSH_BACK;
                if (r < 52) return FN_POP_FRONT;
                if (r < 68) return FN_POP_BACK;
                if (r < 84) return FN_CONTAINS;
                return FN_REMOVE;
            end
        endcase
    endfunction

    // small pool keeps search and remove hitting; the rest sweeps all bits
    function automatic logic [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return val_pool[$urandom_range(0, 7)];
        if (r < 85) return $urandom();
        return val_pool[$urandom_range(0, 3)];
    endfunction

    initial begin : rx_pattern
        int seg;
        int pct;
        bit held;
        held = 1'b0;
        wait (aresetn);
        forever begin
            if (!held && n_sent >= 600) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
            end
            seg = $urandom_range(5, 80);
            case ($urandom_range(0, 2))
                0:       pct = 0;
                1:       pct = 30;
                default: pct = 70;
            endcase
            repeat (seg) begin
                m_tready <= ($urandom_range(0, 99) >= pct);
                @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        traffic_t mode;
        int run_len;
        for (int i = 0; i < 8; i++) val_pool[i] = $urandom();
        val_pool[0] = 32'h8000_0000;
        val_pool[1] = 32'h7fff_ffff;
        val_pool[2] = 32'h0000_0000;
        val_pool[3] = 32'hffff_ffff;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty store, unused codes, then pushes with a duplicate and removes
        drive_op(FN_POP_FRONT, 32'h1234_5678);
        drive_op(FN_POP_BACK, 32'hedcb_a987);
        drive_op(FN_CONTAINS, 32'h0000_0000);
        drive_op(FN_REMOVE, 32'h0000_0000);
        drive_op(FN_NOP6, 32'hffff_ffff);
        drive_op(FN_NOP7, 32'h0000_0000);
        drive_op(FN_PUSH_FRONT, 32'h8000_0000);
        drive_op(FN_PUSH_BACK, 32'h7fff_ffff);
        drive_op(FN_PUSH_FRONT, 32'hffff_ffff);
        drive_op(FN_PUSH_BACK, 32'h0000_0000);
        drive_op(FN_PUSH_BACK, 32'h0000_0005);
        drive_op(FN_PUSH_FRONT, 32'h0000_0005);
        drive_op(FN_PUSH_BACK, 32'haaaa_aaaa);
        drive_op(FN_CONTAINS, 32'h0000_0000);
        drive_op(FN_CONTAINS, 32'h0000_007b);
        drive_op(FN_REMOVE, 32'h0000_0005);
        drive_op(FN_REMOVE, 32'h0000_0000);
        drive_op(FN_REMOVE, 32'haaaa_aaaa);
        drive_op(FN_REMOVE, 32'h0000_004d);
        drive_op(FN_NOP6, 32'h5555_5555);
        drive_op(FN_POP_FRONT, 32'h0000_0000);
        drive_op(FN_POP_BACK, 32'h0000_0000);
        drive_op(FN_POP_FRONT, 32'h0000_0000);
        drive_op(FN_POP_BACK, 32'h0000_0000);
        drive_op(FN_POP_BACK, 32'h0000_0000);
        n_directed = n_sent;

        mode = MODE_FILL;
        run_len = 40;
        while (n_sent < n_directed + N_RANDOM) begin
            repeat (run_len) drive_op(pick_func(mode), pick_value());
            mode = traffic_t'($urandom_range(0, 2));
            run_len = $urandom_range(10, 60);
            val_pool[$urandom_range(4, 7)] = $urandom();
        end
        s_tvalid <= 1'b0;

        while (sb.outcomes_due.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Ran %0d operations (%0d directed) in fill, drain and mixed phases; %0d results checked.",
                 n_sent, n_directed, sb.n_checked);
        $display("Saw %0d full drops, %0d empty pops, %0d misses, %0d hits; peak fill %0d of %0d.",
                 sb.n_full, sb.n_empty, sb.n_miss, sb.n_hit, sb.peak, DEPTH);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/dqsr_pkg.sv
design/dqsr_datapath.sv
design/dqsr_ctrl.sv
design/deque_with_search_remove_core.sv
sim/deque_with_search_remove_core_test.sv
